// ===== hdl/sdsh_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package sdsh_pkg;

    localparam int unsigned DEF_BLOCK_BYTES      = 512;
    localparam int unsigned DEF_INIT_DUMMY_BYTES = 10;
    localparam int unsigned POLL_W               = 16;
    localparam logic [POLL_W-1:0] POLL_LIMIT_RST = 16'hFFFF;

    localparam int unsigned FRAME_BYTES    = 6;
    localparam int unsigned READ_PRE_BYTES = 4;
    localparam int unsigned CRC_BYTES      = 2;

    localparam logic [7:0] CODE_CMD0  = 8'h40;
    localparam logic [7:0] CODE_CMD1  = 8'h41;
    localparam logic [7:0] CODE_CMD17 = 8'h51;
    localparam logic [7:0] CODE_CMD24 = 8'h58;
    localparam logic [7:0] FRAME_CRC  = 8'h95;
    localparam logic [7:0] TOK_START  = 8'hFE;
    localparam logic [7:0] BYTE_IDLE  = 8'hFF;
    localparam logic [7:0] R1_IDLE    = 8'h01;
    localparam logic [7:0] DRESP_MASK = 8'h05;

    typedef enum logic [1:0] {
        CMD_XCHG  = 2'd0,
        CMD_INIT  = 2'd1,
        CMD_READ  = 2'd2,
        CMD_WRITE = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_NO_CARD  = 3'd1,
        ST_WPROT    = 3'd2,
        ST_RST_REJ  = 3'd3,
        ST_INIT_TO  = 3'd4,
        ST_RD_FAIL  = 3'd5,
        ST_WR_FAIL  = 3'd6,
        ST_RSVD     = 3'd7
    } t_status;

    typedef enum logic [23:0] {
        PH_IDLE     = 24'h000001,
        PH_DUMMY    = 24'h000002,
        PH_F0       = 24'h000004,
        PH_R0       = 24'h000008,
        PH_GAP0     = 24'h000010,
        PH_F1       = 24'h000020,
        PH_R1       = 24'h000040,
        PH_T1_AGAIN = 24'h000080,
        PH_T1_OK    = 24'h000100,
        PH_T1_FAIL  = 24'h000200,
        PH_RPRE     = 24'h000400,
        PH_FRW      = 24'h000800,
        PH_RRW      = 24'h001000,
        PH_RGAP     = 24'h002000,
        PH_RTOK     = 24'h004000,
        PH_RDATA    = 24'h008000,
        PH_RCRC     = 24'h010000,
        PH_WGAP     = 24'h020000,
        PH_WDATA    = 24'h040000,
        PH_WLAST    = 24'h080000,
        PH_WCRC1    = 24'h100000,
        PH_WCRC2    = 24'h200000,
        PH_WRESP    = 24'h400000,
        PH_WBUSY    = 24'h800000
    } t_phase;

    typedef struct packed {
        logic       send_valid;
        logic [7:0] send_byte;
        logic       chip_select_low;
        logic       want_data;
        logic       read_valid;
        logic [7:0] read_byte;
        logic       done_res;
        logic [2:0] status;
    } t_result;

    function automatic logic [7:0] frame_byte(input logic [7:0] code,
                                              input logic [31:0] addr,
                                              input logic [2:0] idx);
        case (idx)
            3'd0:    frame_byte = code;
            3'd1:    frame_byte = addr[31:24];
            3'd2:    frame_byte = addr[23:16];
            3'd3:    frame_byte = addr[15:8];
            3'd4:    frame_byte = addr[7:0];
            default: frame_byte = FRAME_CRC;
        endcase
    endfunction

endpackage

`default_nettype wire

// ===== hdl/sdsh_seq.sv =====
`timescale 1ns / 1ps
`default_nettype none

module sdsh_seq
    import sdsh_pkg::*;
#(
    parameter int unsigned BLOCK_BYTES      = DEF_BLOCK_BYTES,
    parameter int unsigned INIT_DUMMY_BYTES = DEF_INIT_DUMMY_BYTES
) (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_step,
    input  wire [1:0]        i_cmd,
    input  wire [31:0]       i_address,
    input  wire              i_card_absent,
    input  wire              i_write_protect,
    input  wire [7:0]        i_miso_byte,
    input  wire [7:0]        i_data_in,
    input  wire [POLL_W-1:0] i_poll_limit,
    output t_result          o_result
);

    localparam int unsigned CNT_W = ($clog2(BLOCK_BYTES) > 6) ? $clog2(BLOCK_BYTES) : 6;

    t_phase            r_phase, n_phase;
    t_cmd              r_operation, n_operation;
    logic [CNT_W-1:0]  r_byte_count, n_byte_count;
    logic [POLL_W-1:0] r_poll_count, n_poll_count;
    logic [POLL_W-1:0] r_retry_count, n_retry_count;
    logic [31:0]       r_address_hold, n_address_hold;
    logic              r_select, n_select;

    logic [CNT_W-1:0]  cnt_inc;
    logic [POLL_W-1:0] poll_inc;
    logic [POLL_W-1:0] retry_inc;
    logic [7:0]        rw_code;
    logic [7:0]        cur_code;
    t_result           res;

    assign cnt_inc   = r_byte_count + CNT_W'(1);
    assign poll_inc  = r_poll_count + POLL_W'(1);
    assign retry_inc = r_retry_count + POLL_W'(1);
    assign rw_code   = (r_operation == CMD_WRITE) ? CODE_CMD24 : CODE_CMD17;
    assign cur_code  = (r_phase == PH_F0) ? CODE_CMD0 :
                       (r_phase == PH_F1) ? CODE_CMD1 : rw_code;

    always_comb begin
        n_phase        = r_phase;
        n_operation    = r_operation;
        n_byte_count   = r_byte_count;
        n_poll_count   = r_poll_count;
        n_retry_count  = r_retry_count;
        n_address_hold = r_address_hold;
        n_select       = r_select;
        res            = '0;

        if (t_cmd'(i_cmd) != CMD_XCHG) begin
            n_operation = t_cmd'(i_cmd);
            n_phase     = PH_IDLE;
            if (i_card_absent) begin
                res.done_res = 1'b1;
                res.status   = ST_NO_CARD;
            end else if (t_cmd'(i_cmd) == CMD_INIT) begin
                n_address_hold = '0;
                n_select       = 1'b0;
                n_byte_count   = '0;
                n_phase        = PH_DUMMY;
                res.send_valid = 1'b1;
                res.send_byte  = BYTE_IDLE;
            end else if (t_cmd'(i_cmd) == CMD_READ) begin
                n_address_hold = i_address;
                n_byte_count   = '0;
                n_phase        = PH_RPRE;
                res.send_valid = 1'b1;
                res.send_byte  = BYTE_IDLE;
            end else if (i_write_protect) begin
                res.done_res = 1'b1;
                res.status   = ST_WPROT;
            end else begin
                n_address_hold = i_address;
                n_byte_count   = '0;
                n_phase        = PH_FRW;
                res.send_valid = 1'b1;
                res.send_byte  = CODE_CMD24;
            end
        end else begin
            unique case (r_phase)
                PH_IDLE: begin
                end
                PH_DUMMY: begin
                    res.send_valid = 1'b1;
                    if (cnt_inc < CNT_W'(INIT_DUMMY_BYTES)) begin
                        n_byte_count  = cnt_inc;
                        res.send_byte = BYTE_IDLE;
                    end else begin
                        n_select      = 1'b1;
                        n_byte_count  = '0;
                        n_phase       = PH_F0;
                        res.send_byte = CODE_CMD0;
                    end
                end
                PH_F0, PH_F1, PH_FRW: begin
                    res.send_valid = 1'b1;
                    n_byte_count   = cnt_inc;
                    if (cnt_inc < CNT_W'(FRAME_BYTES)) begin
                        res.send_byte = frame_byte(cur_code, r_address_hold, cnt_inc[2:0]);
                    end else begin
                        n_poll_count  = '0;
                        res.send_byte = BYTE_IDLE;
                        unique case (r_phase)
                            PH_F0:   n_phase = PH_R0;
                            PH_F1:   n_phase = PH_R1;
                            default: n_phase = PH_RRW;
                        endcase
                    end
                end
                PH_R0, PH_R1, PH_RRW: begin
                    n_poll_count = poll_inc;
                    if (i_miso_byte[7] && poll_inc < i_poll_limit) begin
                        res.send_valid = 1'b1;
                        res.send_byte  = BYTE_IDLE;
                    end else if (r_phase == PH_R0) begin
                        if (i_miso_byte != R1_IDLE) begin
                            n_phase      = PH_IDLE;
                            res.done_res = 1'b1;
                            res.status   = ST_RST_REJ;
                        end else begin
                            n_retry_count  = '0;
                            n_phase        = PH_GAP0;
                            res.send_valid = 1'b1;
                            res.send_byte  = BYTE_IDLE;
                        end
                    end else if (r_phase == PH_R1) begin
                        n_retry_count  = retry_inc;
                        res.send_valid = 1'b1;
                        res.send_byte  = BYTE_IDLE;
                        priority if (i_miso_byte != 8'h00 && retry_inc < i_poll_limit) begin
                            n_phase = PH_T1_AGAIN;
                        end else if (retry_inc >= i_poll_limit) begin
                            n_phase = PH_T1_FAIL;
                        end else begin
                            n_phase = PH_T1_OK;
                        end
                    end else if (i_miso_byte != 8'h00) begin
                        n_phase      = PH_IDLE;
                        res.done_res = 1'b1;
                        res.status   = (r_operation == CMD_WRITE) ? ST_WR_FAIL : ST_RD_FAIL;
                    end else begin
                        n_byte_count   = '0;
                        n_phase        = (r_operation == CMD_WRITE) ? PH_WGAP : PH_RGAP;
                        res.send_valid = 1'b1;
                        res.send_byte  = BYTE_IDLE;
                    end
                end
                PH_GAP0, PH_T1_AGAIN: begin
                    n_byte_count   = '0;
                    n_phase        = PH_F1;
                    res.send_valid = 1'b1;
                    res.send_byte  = CODE_CMD1;
                end
                PH_T1_OK: begin
                    n_phase      = PH_IDLE;
                    res.done_res = 1'b1;
                    res.status   = ST_OK;
                end
                PH_T1_FAIL: begin
                    n_phase      = PH_IDLE;
                    res.done_res = 1'b1;
                    res.status   = ST_INIT_TO;
                end
                PH_RPRE: begin
                    res.send_valid = 1'b1;
                    if (cnt_inc < CNT_W'(READ_PRE_BYTES)) begin
                        n_byte_count  = cnt_inc;
                        res.send_byte = BYTE_IDLE;
                    end else begin
                        n_byte_count  = '0;
                        n_phase       = PH_FRW;
                        res.send_byte = rw_code;
                    end
                end
                PH_RGAP: begin
                    n_byte_count   = cnt_inc;
                    res.send_valid = 1'b1;
                    res.send_byte  = BYTE_IDLE;
                    if (cnt_inc >= CNT_W'(CRC_BYTES)) begin
                        n_poll_count = '0;
                        n_phase      = PH_RTOK;
                    end
                end
                PH_RTOK: begin
                    n_poll_count = poll_inc;
                    priority if (i_miso_byte != TOK_START && poll_inc < i_poll_limit) begin
                        res.send_valid = 1'b1;
                        res.send_byte  = BYTE_IDLE;
                    end else if (poll_inc >= i_poll_limit) begin
                        n_phase      = PH_IDLE;
                        res.done_res = 1'b1;
                        res.status   = ST_RD_FAIL;
                    end else begin
                        n_byte_count   = '0;
                        n_phase        = PH_RDATA;
                        res.send_valid = 1'b1;
                        res.send_byte  = BYTE_IDLE;
                    end
                end
                PH_RDATA: begin
                    res.read_valid = 1'b1;
                    res.read_byte  = i_miso_byte;
                    res.send_valid = 1'b1;
                    res.send_byte  = BYTE_IDLE;
                    if (r_byte_count >= CNT_W'(BLOCK_BYTES - 1)) begin
                        n_byte_count = '0;
                        n_phase      = PH_RCRC;
                    end else begin
                        n_byte_count = cnt_inc;
                    end
                end
                PH_RCRC: begin
                    n_byte_count = cnt_inc;
                    if (cnt_inc < CNT_W'(CRC_BYTES)) begin
                        res.send_valid = 1'b1;
                        res.send_byte  = BYTE_IDLE;
                    end else begin
                        n_phase      = PH_IDLE;
                        res.done_res = 1'b1;
                        res.status   = ST_OK;
                    end
                end
                PH_WGAP: begin
                    n_byte_count   = '0;
                    n_phase        = PH_WDATA;
                    res.want_data  = 1'b1;
                    res.send_valid = 1'b1;
                    res.send_byte  = TOK_START;
                end
                PH_WDATA: begin
                    res.send_valid = 1'b1;
                    res.send_byte  = i_data_in;
                    if (r_byte_count >= CNT_W'(BLOCK_BYTES - 1)) begin
                        n_phase = PH_WLAST;
                    end else begin
                        n_byte_count  = cnt_inc;
                        res.want_data = 1'b1;
                    end
                end
                PH_WLAST, PH_WCRC1, PH_WCRC2: begin
                    res.send_valid = 1'b1;
                    res.send_byte  = BYTE_IDLE;
                    unique case (r_phase)
                        PH_WLAST: n_phase = PH_WCRC1;
                        PH_WCRC1: n_phase = PH_WCRC2;
                        default:  n_phase = PH_WRESP;
                    endcase
                end
                PH_WRESP: begin
                    if ((i_miso_byte & DRESP_MASK) != DRESP_MASK) begin
                        n_phase      = PH_IDLE;
                        res.done_res = 1'b1;
                        res.status   = ST_WR_FAIL;
                    end else begin
                        n_poll_count   = '0;
                        n_phase        = PH_WBUSY;
                        res.send_valid = 1'b1;
                        res.send_byte  = BYTE_IDLE;
                    end
                end
                PH_WBUSY: begin
                    n_poll_count = poll_inc;
                    priority if (i_miso_byte != BYTE_IDLE && poll_inc < i_poll_limit) begin
                        res.send_valid = 1'b1;
                        res.send_byte  = BYTE_IDLE;
                    end else if (poll_inc >= i_poll_limit) begin
                        n_phase      = PH_IDLE;
                        res.done_res = 1'b1;
                        res.status   = ST_WR_FAIL;
                    end else begin
                        n_phase      = PH_IDLE;
                        res.done_res = 1'b1;
                        res.status   = ST_OK;
                    end
                end
                default: begin
                    n_phase = PH_IDLE;
                end
            endcase
        end
        res.chip_select_low = n_select;
    end

    assign o_result = res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase        <= PH_IDLE;
            r_operation    <= CMD_XCHG;
            r_byte_count   <= '0;
            r_poll_count   <= '0;
            r_retry_count  <= '0;
            r_address_hold <= '0;
            r_select       <= 1'b0;
        end else if (i_step) begin
            r_phase        <= n_phase;
            r_operation    <= n_operation;
            r_byte_count   <= n_byte_count;
            r_poll_count   <= n_poll_count;
            r_retry_count  <= n_retry_count;
            r_address_hold <= n_address_hold;
            r_select       <= n_select;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/sd_spi_block_host_core.sv =====
// Each input word is registered in the input stage, its result word in the output register.
// Throughput: one word per cycle unless stalled; the sequencer state updates with the result.
// Stalls: the input stage holds one word and the output register one result.
// Reset: synchronous, active low; sequencer idle, card deselected, poll limit 65535.
`timescale 1ns / 1ps
`default_nettype none

module sd_spi_block_host_core
    import sdsh_pkg::*;
#(
    parameter int unsigned BLOCK_BYTES      = DEF_BLOCK_BYTES,
    parameter int unsigned INIT_DUMMY_BYTES = DEF_INIT_DUMMY_BYTES
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    // address[31:0], card_absent[32], write_protect[33], miso_byte[41:34], data_in[49:42]
    input  wire [55:0]  s_axis_tdata,
    // cmd[1:0]
    input  wire [1:0]   s_axis_tuser,
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    // send_valid[0], send_byte[8:1], chip_select_low[9], want_data[10], read_valid[11],
    // read_byte[19:12], done_res[20], status[23:21]
    output logic [23:0] m_axis_tdata,
    input  wire         i_cfg_valid,
    output logic        o_cfg_ready,
    input  wire [15:0]  i_cfg_data
);

    logic              r_in_valid;
    logic [49:0]       r_in_data;
    logic [1:0]        r_in_cmd;
    logic              r_out_valid;
    t_result           r_out;
    logic [POLL_W-1:0] r_poll_limit;
    logic              advance;
    t_result           seq_result;

    assign advance       = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || advance;
    assign o_cfg_ready   = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_poll_limit <= POLL_LIMIT_RST;
        end else if (i_cfg_valid) begin
            r_poll_limit <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_data <= s_axis_tdata[49:0];
            r_in_cmd  <= s_axis_tuser;
        end
    end

    sdsh_seq #(
        .BLOCK_BYTES      (BLOCK_BYTES),
        .INIT_DUMMY_BYTES (INIT_DUMMY_BYTES)
    ) u_seq (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_step          (advance),
        .i_cmd           (r_in_cmd),
        .i_address       (r_in_data[31:0]),
        .i_card_absent   (r_in_data[32]),
        .i_write_protect (r_in_data[33]),
        .i_miso_byte     (r_in_data[41:34]),
        .i_data_in       (r_in_data[49:42]),
        .i_poll_limit    (r_poll_limit),
        .o_result        (seq_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= seq_result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out.status, r_out.done_res, r_out.read_byte, r_out.read_valid,
                            r_out.want_data, r_out.chip_select_low, r_out.send_byte,
                            r_out.send_valid};

endmodule

`default_nettype wire

// ===== bench/sd_spi_block_host_core_tb.sv =====
`timescale 1ns / 1ps

module sd_spi_block_host_core_tb
    import sdsh_pkg::*;
;

    localparam int unsigned BLK          = DEF_BLOCK_BYTES;
    localparam int unsigned DUMMIES      = DEF_INIT_DUMMY_BYTES;
    localparam int unsigned RD_GAP_BYTES = 2;
    localparam int unsigned LATENCY      = 2;
    localparam int unsigned PHASE_ITEMS  = 200;
    localparam int unsigned CYCLE_LIMIT  = 500000;
    localparam logic [7:0]  R1_READY     = 8'h00;
    localparam logic [7:0]  BUSY_BYTE    = 8'h00;

    // one result word, laid out as on m_axis_tdata
    typedef struct packed {
        logic [2:0] status;
        logic       done_res;
        logic [7:0] read_byte;
        logic       read_valid;
        logic       want_data;
        logic       chip_select_low;
        logic [7:0] send_byte;
        logic       send_valid;
    } t_host_word;

    class t_host_scoreboard;
        logic [15:0] poll_limit;
        t_phase      phase;
        logic [1:0]  operation;
        logic [9:0]  byte_count;
        logic [15:0] poll_count;
        logic [15:0] retry_count;
        logic [31:0] addr_hold;
        logic        selected;
        t_host_word  nxt;
        t_host_word  due_replies[$];
        int          errors;

        function new();
            poll_limit  = POLL_LIMIT_RST;
            phase       = PH_IDLE;
            operation   = '0;
            byte_count  = '0;
            poll_count  = '0;
            retry_count = '0;
            addr_hold   = '0;
            selected    = 1'b0;
            errors      = 0;
        endfunction

        function void put_byte(logic [7:0] b);
            nxt.send_valid = 1'b1;
            nxt.send_byte  = b;
        endfunction

        function void end_op(t_status st);
            nxt.done_res = 1'b1;
            nxt.status   = st;
            phase        = PH_IDLE;
        endfunction

        function logic [7:0] frame_at(logic [9:0] idx);
            logic [7:0] code;
            if (phase == PH_F0)
                code = CODE_CMD0;
            else if (phase == PH_F1)
                code = CODE_CMD1;
            else
                code = (operation == CMD_WRITE) ? CODE_CMD24 : CODE_CMD17;
            case (idx)
                0: return code;
                1: return addr_hold[31:24];
                2: return addr_hold[23:16];
                3: return addr_hold[15:8];
                4: return addr_hold[7:0];
                default: return FRAME_CRC;
            endcase
        endfunction

        function void open_frame(t_phase ph);
            phase      = ph;
            byte_count = '0;
            put_byte(frame_at(10'd0));
        endfunction

        function void open_poll(t_phase ph);
            phase      = ph;
            poll_count = '0;
            put_byte(BYTE_IDLE);
        endfunction

        function void take_exchange(logic [7:0] miso, logic [7:0] din);
            case (phase)
                PH_DUMMY: begin
                    byte_count = byte_count + 10'd1;
                    if (byte_count < DUMMIES) begin
                        put_byte(BYTE_IDLE);
                    end else begin
                        selected = 1'b1;
                        open_frame(PH_F0);
                    end
                end
                PH_F0, PH_F1, PH_FRW: begin
                    byte_count = byte_count + 10'd1;
                    if (byte_count < FRAME_BYTES)
                        put_byte(frame_at(byte_count));
                    else if (phase == PH_F0)
                        open_poll(PH_R0);
                    else if (phase == PH_F1)
                        open_poll(PH_R1);
                    else
                        open_poll(PH_RRW);
                end
                PH_R0, PH_R1, PH_RRW: begin
                    poll_count = poll_count + 16'd1;
                    if (miso[7] && poll_count < poll_limit) begin
                        put_byte(BYTE_IDLE);
                    end else if (phase == PH_R0) begin
                        if (miso != R1_IDLE) begin
                            end_op(ST_RST_REJ);
                        end else begin
                            retry_count = '0;
                            phase = PH_GAP0;
                            put_byte(BYTE_IDLE);
                        end
                    end else if (phase == PH_R1) begin
                        retry_count = retry_count + 16'd1;
                        if (miso != R1_READY && retry_count < poll_limit)
                            phase = PH_T1_AGAIN;
                        else if (retry_count >= poll_limit)
                            phase = PH_T1_FAIL;
                        else
                            phase = PH_T1_OK;
                        put_byte(BYTE_IDLE);
                    end else if (miso != R1_READY) begin
                        end_op(operation == CMD_WRITE ? ST_WR_FAIL : ST_RD_FAIL);
                    end else begin
                        byte_count = '0;
                        phase = (operation == CMD_WRITE) ? PH_WGAP : PH_RGAP;
                        put_byte(BYTE_IDLE);
                    end
                end
                PH_GAP0, PH_T1_AGAIN: open_frame(PH_F1);
                PH_T1_OK:   end_op(ST_OK);
                PH_T1_FAIL: end_op(ST_INIT_TO);
                PH_RPRE: begin
                    byte_count = byte_count + 10'd1;
                    if (byte_count < READ_PRE_BYTES)
                        put_byte(BYTE_IDLE);
                    else
                        open_frame(PH_FRW);
                end
                PH_RGAP: begin
                    byte_count = byte_count + 10'd1;
                    if (byte_count < RD_GAP_BYTES)
                        put_byte(BYTE_IDLE);
                    else
                        open_poll(PH_RTOK);
                end
                PH_RTOK: begin
                    poll_count = poll_count + 16'd1;
                    if (miso != TOK_START && poll_count < poll_limit) begin
                        put_byte(BYTE_IDLE);
                    end else if (poll_count >= poll_limit) begin
                        end_op(ST_RD_FAIL);
                    end else begin
                        byte_count = '0;
                        phase = PH_RDATA;
                        put_byte(BYTE_IDLE);
                    end
                end
                PH_RDATA: begin
                    nxt.read_valid = 1'b1;
                    nxt.read_byte  = miso;
                    if (byte_count >= BLK - 1) begin
                        byte_count = '0;
                        phase = PH_RCRC;
                    end else begin
                        byte_count = byte_count + 10'd1;
                    end
                    put_byte(BYTE_IDLE);
                end
                PH_RCRC: begin
                    byte_count = byte_count + 10'd1;
                    if (byte_count < CRC_BYTES)
                        put_byte(BYTE_IDLE);
                    else
                        end_op(ST_OK);
                end
                PH_WGAP: begin
                    byte_count = '0;
                    phase = PH_WDATA;
                    nxt.want_data = 1'b1;
                    put_byte(TOK_START);
                end
                PH_WDATA: begin
                    put_byte(din);
                    if (byte_count >= BLK - 1) begin
                        phase = PH_WLAST;
                    end else begin
                        byte_count = byte_count + 10'd1;
                        nxt.want_data = 1'b1;
                    end
                end
                PH_WLAST: begin
                    phase = PH_WCRC1;
                    put_byte(BYTE_IDLE);
                end
                PH_WCRC1: begin
                    phase = PH_WCRC2;
                    put_byte(BYTE_IDLE);
                end
                PH_WCRC2: begin
                    phase = PH_WRESP;
                    put_byte(BYTE_IDLE);
                end
                PH_WRESP: begin
                    if ((miso & DRESP_MASK) != DRESP_MASK)
                        end_op(ST_WR_FAIL);
                    else
                        open_poll(PH_WBUSY);
                end
                PH_WBUSY: begin
                    poll_count = poll_count + 16'd1;
                    if (miso != BYTE_IDLE && poll_count < poll_limit)
                        put_byte(BYTE_IDLE);
                    else if (poll_count >= poll_limit)
                        end_op(ST_WR_FAIL);
                    else
                        end_op(ST_OK);
                end
                default: phase = PH_IDLE;
            endcase
        endfunction

        function void note_request(logic [1:0] cmd, logic [31:0] addr, logic absent,
                                   logic wp, logic [7:0] miso, logic [7:0] din);
            nxt = '0;
            if (cmd != CMD_XCHG) begin
                operation = cmd;
                phase     = PH_IDLE;
                if (absent) begin
                    end_op(ST_NO_CARD);
                end else if (cmd == CMD_INIT) begin
                    addr_hold  = '0;
                    selected   = 1'b0;
                    byte_count = '0;
                    phase      = PH_DUMMY;
                    put_byte(BYTE_IDLE);
                end else if (cmd == CMD_READ) begin
                    addr_hold  = addr;
                    byte_count = '0;
                    phase      = PH_RPRE;
                    put_byte(BYTE_IDLE);
                end else if (wp) begin
                    end_op(ST_WPROT);
                end else begin
                    addr_hold = addr;
                    open_frame(PH_FRW);
                end
            end else if (phase != PH_IDLE) begin
                take_exchange(miso, din);
            end
            nxt.chip_select_low = selected;
            due_replies.push_back(nxt);
        endfunction

        function string show(t_host_word w);
            return $sformatf("sv=%0d sb=%02h cs=%0d wd=%0d rv=%0d rb=%02h done=%0d st=%0d",
                             w.send_valid, w.send_byte, w.chip_select_low, w.want_data,
                             w.read_valid, w.read_byte, w.done_res, w.status);
        endfunction

        function void check_reply(logic [23:0] raw);
            t_host_word got;
            t_host_word want;
            got = raw;
            if (due_replies.size() == 0) begin
                if (errors < 10)
                    $display("unexpected word: %s", show(got));
                errors++;
            end else begin
                want = due_replies.pop_front();
                if (got !== want) begin
                    if (errors < 10)
                        $display("mismatch: expected %s / actual %s", show(want), show(got));
                    errors++;
                end
            end
        endfunction
    endclass

    logic        i_clk          = 1'b0;
    logic        i_rst_n        = 1'b0;
    logic        s_axis_tvalid  = 1'b0;
    logic [55:0] s_axis_tdata   = '0;
    logic [1:0]  s_axis_tuser   = '0;
    logic        m_axis_tready  = 1'b0;
    logic        i_cfg_valid    = 1'b0;
    logic [15:0] i_cfg_data     = '0;
    wire         s_axis_tready;
    wire         m_axis_tvalid;
    wire [23:0]  m_axis_tdata;
    wire         o_cfg_ready;

    t_host_scoreboard sb;
    int unsigned cycles     = 0;
    int unsigned gap_rate   = 0;
    int unsigned stall_rate = 0;

    sd_spi_block_host_core #(
        .BLOCK_BYTES      (BLK),
        .INIT_DUMMY_BYTES (DUMMIES)
    ) uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    always @(negedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= stall_rate);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_reply(m_axis_tdata);
    end

    // card side: plausible replies for the wait the sequencer is in
    function automatic logic [7:0] card_byte();
        logic [7:0] r;
        r = 8'($urandom);
        case (sb.phase)
            PH_R0:
                if ($urandom_range(3) == 0) r = r | 8'h80;
                else if ($urandom_range(7) != 0) r = R1_IDLE;
            PH_R1:
                if ($urandom_range(3) == 0) r = r | 8'h80;
                else if ($urandom_range(1) == 0) r = R1_READY;
                else if ($urandom_range(7) != 0) r = R1_IDLE;
            PH_RRW:
                if ($urandom_range(3) == 0) r = r | 8'h80;
                else if ($urandom_range(7) != 0) r = R1_READY;
            PH_RTOK:
                if ($urandom_range(3) == 0) r = TOK_START;
                else if ($urandom_range(7) != 0) r = BYTE_IDLE;
            PH_WRESP:
                if ($urandom_range(7) != 0) r = r | DRESP_MASK;
            PH_WBUSY:
                if ($urandom_range(3) == 0) r = BYTE_IDLE;
                else if ($urandom_range(3) != 0) r = BUSY_BYTE;
            default: ;
        endcase
        return r;
    endfunction

    // entered and left just after a falling edge
    task automatic push_word(input logic [1:0] cmd, input logic [31:0] addr,
                             input logic absent, input logic wp,
                             input logic [7:0] miso, input logic [7:0] din);
        while (gap_rate != 0 && $urandom_range(99) < gap_rate) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= {6'd0, din, miso, wp, absent, addr};
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_request(cmd, addr, absent, wp, miso, din);
        @(negedge i_clk);
    endtask

    task automatic random_word();
        logic [1:0]  cmd;
        logic [31:0] addr;
        logic        absent;
        logic        wp;
        logic        start;
        cmd    = CMD_XCHG;
        addr   = $urandom;
        absent = 1'($urandom_range(1));
        wp     = 1'($urandom_range(1));
        // mostly starts when idle, rare aborts mid-operation
        start  = (sb.phase == PH_IDLE) ? ($urandom_range(7) != 0) : ($urandom_range(399) == 0);
        if (start) begin
            cmd    = 2'($urandom_range(3, 1));
            absent = ($urandom_range(9) == 0);
            wp     = ($urandom_range(5) == 0);
            if ($urandom_range(7) == 0)
                addr = $urandom_range(1) ? 32'hFFFF_FFFF : 32'h0;
        end
        push_word(cmd, addr, absent, wp, card_byte(), 8'($urandom));
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (sb.due_replies.size() != 0)
            @(posedge i_clk);
        repeat (LATENCY + 2) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic write_limit(input logic [15:0] v);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.poll_limit = v;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    initial begin
        logic [15:0] lim;
        sb = new();
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        write_limit(16'hFFFF);

        // exchanges while idle, missing card, protected card
        push_word(CMD_XCHG, 32'hFFFF_FFFF, 1'b1, 1'b1, 8'hFF, 8'hFF);
        push_word(CMD_XCHG, 32'h0, 1'b0, 1'b0, 8'h00, 8'h00);
        push_word(CMD_READ, 32'h1234_5678, 1'b1, 1'b0, 8'h00, 8'h00);
        push_word(CMD_WRITE, 32'hFFFF_FFFF, 1'b1, 1'b1, 8'hFF, 8'hFF);
        push_word(CMD_INIT, 32'h0, 1'b1, 1'b0, 8'h00, 8'h00);
        push_word(CMD_WRITE, 32'h0, 1'b0, 1'b1, 8'h00, 8'h00);
        // protect pin is ignored on a read
        push_word(CMD_READ, 32'hFFFF_FFFF, 1'b0, 1'b1, 8'h00, 8'h00);
        repeat (10)
            push_word(CMD_XCHG, $urandom, 1'($urandom_range(1)), 1'($urandom_range(1)),
                      8'hFF, 8'($urandom));
        push_word(CMD_XCHG, 32'h0, 1'b0, 1'b0, 8'h00, 8'h00);
        // new starts abandon the operation in progress
        push_word(CMD_WRITE, 32'h0, 1'b0, 1'b0, 8'h00, 8'h00);
        repeat (2) push_word(CMD_XCHG, 32'h0, 1'b0, 1'b0, 8'hFF, 8'h00);
        push_word(CMD_INIT, 32'hFFFF_FFFF, 1'b0, 1'b1, 8'h00, 8'h00);
        repeat (3) push_word(CMD_XCHG, 32'hFFFF_FFFF, 1'b1, 1'b1, 8'h00, 8'hFF);
        drain();

        for (int p = 0; p < 8; p++) begin
            case (p)
                0: lim = 16'hFFFF;
                1: lim = 16'd1;
                2: lim = 16'd2;
                3: lim = 16'($urandom_range(8, 3));
                4: lim = 16'hFFFF;
                5: lim = 16'd1;
                6: lim = 16'($urandom_range(65535, 1));
                default: lim = 16'd4;
            endcase
            case (p % 4)
                0: begin gap_rate = 0;  stall_rate = 0;  end
                1: begin gap_rate = 83; stall_rate = 0;  end
                2: begin gap_rate = 0;  stall_rate = 83; end
                default: begin gap_rate = 36; stall_rate = 36; end
            endcase
            write_limit(lim);
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                if (i == PHASE_ITEMS / 2)
                    drain();
                random_word();
            end
            drain();
        end

        if (sb.due_replies.size() != 0) begin
            if (sb.errors < 10)
                $display("missing result words: %0d", sb.due_replies.size());
            sb.errors += sb.due_replies.size();
        end
        if (sb.errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// ===== sim.f =====
hdl/sdsh_pkg.sv
hdl/sdsh_seq.sv
hdl/sd_spi_block_host_core.sv
bench/sd_spi_block_host_core_tb.sv
